[rtl/camera_packet_frame_assembler_defines.svh]
// ----------------------------------------------------------------------------
// Camera packet frame assembler: assertion macros
// Shared assertion forms used at the end of the RTL modules.
// ----------------------------------------------------------------------------
`ifndef CAMERA_PACKET_FRAME_ASSEMBLER_DEFINES_SVH
`define CAMERA_PACKET_FRAME_ASSEMBLER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CPFA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CPFA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cpfa_pkg.sv]
// ----------------------------------------------------------------------------
// Camera packet frame assembler package
// Sizes, protocol constants, codes and shared types of the assembler.
// ----------------------------------------------------------------------------
package cpfa_pkg;

    localparam int PACKET_WORDS = 16;
    localparam int OFFSET_BITS  = 17;

    localparam int POS_W     = $clog2(PACKET_WORDS);
    localparam int MEM_AW    = POS_W + 1;
    localparam int MEM_DEPTH = 2 ** MEM_AW;

    localparam int WORD_W      = 32;
    localparam int HALF_W      = WORD_W / 2;
    localparam int LEN_W       = 18;
    localparam int BAD_W       = 3;
    localparam int KIND_W      = 3;
    localparam int CONF_W      = 8;
    localparam int CHAR_W      = 8;
    localparam int LABEL_CHARS = 6;
    localparam int LABEL_W     = LABEL_CHARS * CHAR_W;
    localparam int CFG_IDX_W   = 2;
    localparam int BYTES_PER_WORD = 4;
    localparam int SUM_W = ((LEN_W > OFFSET_BITS) ? LEN_W : OFFSET_BITS) + 2;

    localparam int CMD_DEPTH = 2;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);

    localparam logic [POS_W-1:0]  LAST_POS          = POS_W'(PACKET_WORDS - 1);
    localparam logic [WORD_W-1:0] SYNC_WORD         = 32'hFF00FF00;
    localparam logic [HALF_W-1:0] TAG_IMAGE         = 16'hA0A0;
    localparam logic [HALF_W-1:0] TAG_LABEL         = 16'hC0C0;
    localparam logic [CHAR_W-1:0] CHAR_SPACE        = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_NUL          = 8'h00;
    localparam logic [LEN_W-1:0]  RESET_FRAME_BYTES = LEN_W'(76800);
    localparam logic [LEN_W-1:0]  RESET_MIN_BYTES   = LEN_W'(69120);
    localparam logic [BAD_W-1:0]  RESET_BAD_LIMIT   = BAD_W'(5);
    localparam logic [LEN_W-1:0]  LEN_MAX           = '1;
    localparam logic [BAD_W-1:0]  BAD_MAX           = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_BYTES     = 2'd0,
        REG_MIN_FRAME_BYTES = 2'd1,
        REG_BAD_LIMIT       = 2'd2
    } t_cfg_reg;

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL    = 3'd0,
        KIND_COMPLETE = 3'd1,
        KIND_WRONG    = 3'd2,
        KIND_SHORT    = 3'd3,
        KIND_ABORT    = 3'd4,
        KIND_LABEL    = 3'd5
    } t_kind;

    typedef enum logic [1:0] {
        PKT_SYNC,
        PKT_LABEL,
        PKT_IMAGE
    } t_pkt;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LOAD,
        BK_RUN
    } t_back_state;

    typedef struct packed {
        logic [LEN_W-1:0] frame_bytes;
        logic [LEN_W-1:0] min_frame_bytes;
        logic [BAD_W-1:0] bad_frame_limit;
    } t_cfg;

    typedef struct packed {
        t_pkt               ptype;
        logic               bank;
        logic [LABEL_W-1:0] label_raw;
        logic [CONF_W-1:0]  conf;
    } t_cmd;

    typedef struct packed {
        logic              en;
        logic [MEM_AW-1:0] addr;
    } t_rd_req;

    typedef struct packed {
        logic valid;
        logic bank;
    } t_bank_rel;

    typedef struct packed {
        t_kind                  kind;
        logic [OFFSET_BITS-1:0] write_offset;
        logic [WORD_W-1:0]      write_data;
        logic [LABEL_W-1:0]     label_bytes;
        logic [CONF_W-1:0]      confidence;
        logic [BAD_W-1:0]       bad_count;
        logic                   last_result;
    } t_result;

    // Length plus one word, saturating at the top of the counter.
    function automatic logic [LEN_W-1:0] len_step(input logic [LEN_W-1:0] len);
        logic [LEN_W:0] sum;
        sum = {1'b0, len} + (LEN_W + 1)'(BYTES_PER_WORD);
        len_step = sum[LEN_W] ? LEN_MAX : sum[LEN_W-1:0];
    endfunction

    // A word at this offset fits both the frame and the offset range.
    function automatic logic write_fits(input logic [LEN_W-1:0] off,
                                        input logic [LEN_W-1:0] limit);
        logic [SUM_W-1:0] end_pos;
        end_pos = SUM_W'(off) + SUM_W'(BYTES_PER_WORD);
        write_fits = (end_pos <= SUM_W'(limit)) &&
                     (end_pos <= (SUM_W'(1) << OFFSET_BITS));
    endfunction

endpackage

[rtl/cpfa_if.sv]
// ----------------------------------------------------------------------------
// Camera packet frame assembler channels
// Valid/ready channels for received words, results and register writes.
// ----------------------------------------------------------------------------
interface cpfa_rx_if;
    import cpfa_pkg::*;
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] rx_word;
    logic              packet_begin;
    modport source (output valid, output rx_word, output packet_begin, input ready);
    modport sink   (input valid, input rx_word, input packet_begin, output ready);
endinterface

interface cpfa_res_if;
    import cpfa_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [KIND_W-1:0]      kind;
    logic [OFFSET_BITS-1:0] write_offset;
    logic [WORD_W-1:0]      write_data;
    logic [LABEL_W-1:0]     label_bytes;
    logic [CONF_W-1:0]      confidence;
    logic [BAD_W-1:0]       bad_count;
    logic                   last_result;
    modport source (output valid, output kind, output write_offset, output write_data,
                    output label_bytes, output confidence, output bad_count,
                    output last_result, input ready);
    modport sink   (input valid, input kind, input write_offset, input write_data,
                    input label_bytes, input confidence, input bad_count,
                    input last_result, output ready);
endinterface

interface cpfa_cfg_if;
    import cpfa_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [LEN_W-1:0]     wr_data;
    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/cpfa_front.sv]
// ----------------------------------------------------------------------------
// Camera packet frame assembler: front end
// Collects words into a two-bank packet memory and classifies each packet.
// ----------------------------------------------------------------------------
`include "camera_packet_frame_assembler_defines.svh"

module cpfa_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    cpfa_rx_if.sink                     i_rx,
    output cpfa_pkg::t_cmd              o_cmd,
    output logic                        o_cmd_push,
    input  logic                        i_cmd_full,
    input  cpfa_pkg::t_rd_req           i_rd,
    output logic [cpfa_pkg::WORD_W-1:0] o_rd_data,
    input  cpfa_pkg::t_bank_rel         i_rel
);
    import cpfa_pkg::*;

    logic [WORD_W-1:0] r_mem [MEM_DEPTH];
    logic [WORD_W-1:0] r_rd_data;
    logic [WORD_W-1:0] r_w0;
    logic [WORD_W-1:0] r_w1;
    logic [CONF_W-1:0] r_conf;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic              r_bank, n_bank;
    logic [1:0]        r_busy, n_busy;

    logic              accept;
    logic [POS_W-1:0]  pos;
    logic              is_last;
    logic              is_sync;
    logic              is_label;
    logic              is_image;

    assign i_rx.ready = !r_busy[r_bank] && !i_cmd_full;
    assign accept     = i_rx.valid && i_rx.ready;
    assign pos        = i_rx.packet_begin ? '0 : r_pos;
    assign is_last    = (pos == LAST_POS);

    // The head words come from registers, the tail from the word arriving now.
    assign is_sync  = (r_w0 == SYNC_WORD) && (r_w1 == SYNC_WORD);
    assign is_label = (r_w0[WORD_W-1:HALF_W] == TAG_LABEL) &&
                      (i_rx.rx_word[HALF_W-1:0] == TAG_LABEL);
    assign is_image = (r_w0[WORD_W-1:HALF_W] == TAG_IMAGE) &&
                      (i_rx.rx_word[HALF_W-1:0] == TAG_IMAGE);

    assign o_cmd_push = accept && is_last && (is_sync || is_label || is_image);

    always_comb begin
        o_cmd.ptype     = is_sync ? PKT_SYNC : (is_label ? PKT_LABEL : PKT_IMAGE);
        o_cmd.bank      = r_bank;
        o_cmd.label_raw = {r_w0[HALF_W-1:0], r_w1};
        o_cmd.conf      = r_conf;
    end

    always_comb begin
        n_pos  = r_pos;
        n_bank = r_bank;
        n_busy = r_busy;
        if (accept) begin
            n_pos = is_last ? '0 : pos + POS_W'(1);
        end
        if (i_rel.valid) begin
            n_busy[i_rel.bank] = 1'b0;
        end
        // An image packet keeps its bank until the back end has read it out.
        if (o_cmd_push && (o_cmd.ptype == PKT_IMAGE)) begin
            n_busy[r_bank] = 1'b1;
            n_bank         = ~r_bank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_bank <= 1'b0;
            r_busy <= '0;
        end else begin
            r_pos  <= n_pos;
            r_bank <= n_bank;
            r_busy <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[{r_bank, pos}] <= i_rx.rx_word;
            if (pos == POS_W'(0)) begin
                r_w0 <= i_rx.rx_word;
            end
            if (pos == POS_W'(1)) begin
                r_w1 <= i_rx.rx_word;
            end
            if (pos == POS_W'(2)) begin
                r_conf <= i_rx.rx_word[WORD_W-1 -: CONF_W];
            end
        end
        if (i_rd.en) begin
            r_rd_data <= r_mem[i_rd.addr];
        end
    end

    assign o_rd_data = r_rd_data;

    `CPFA_ASSERT_NEXT(a_image_bank_held, i_clk, i_rst_n, o_cmd_push && (o_cmd.ptype == PKT_IMAGE), r_busy[$past(r_bank)], "image packet bank not marked busy")

endmodule

[rtl/cpfa_cmd_fifo.sv]
// ----------------------------------------------------------------------------
// Camera packet frame assembler: command queue
// Short queue of classified packets between the front and back ends.
// ----------------------------------------------------------------------------
`include "camera_packet_frame_assembler_defines.svh"

module cpfa_cmd_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cpfa_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output cpfa_pkg::t_cmd o_head,
    output logic           o_empty,
    output logic           o_full
);
    import cpfa_pkg::*;

    t_cmd              r_q [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [CMD_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CMD_AW:0]   r_count, n_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (CMD_AW + 1)'(CMD_DEPTH));
    assign o_head  = r_q[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_wr_ptr + CMD_AW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == CMD_AW'(CMD_DEPTH - 1)) ? '0 : r_rd_ptr + CMD_AW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + (CMD_AW + 1)'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - (CMD_AW + 1)'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wr_ptr] <= i_cmd;
        end
    end

    `CPFA_ASSERT_NOW(a_no_push_full, i_clk, i_rst_n, i_push, !o_full, "command pushed into a full queue")
    `CPFA_ASSERT_NOW(a_no_pop_empty, i_clk, i_rst_n, i_pop, !o_empty, "command popped from an empty queue")

endmodule

[rtl/cpfa_back.sv]
// ----------------------------------------------------------------------------
// Camera packet frame assembler: back end
// Tracks the frame, replays image packets and registers each result.
// ----------------------------------------------------------------------------
`include "camera_packet_frame_assembler_defines.svh"

module cpfa_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  cpfa_pkg::t_cfg              i_cfg,
    input  cpfa_pkg::t_cmd              i_cmd,
    input  logic                        i_cmd_empty,
    output logic                        o_cmd_pop,
    output cpfa_pkg::t_rd_req           o_rd,
    input  logic [cpfa_pkg::WORD_W-1:0] i_rd_data,
    output cpfa_pkg::t_bank_rel         o_rel,
    cpfa_res_if.source                  o_res
);
    import cpfa_pkg::*;

    t_back_state       r_state, n_state;
    logic              r_open, n_open;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [BAD_W-1:0]  r_bad, n_bad;
    logic              r_bank, n_bank;
    logic [POS_W-1:0]  r_k, n_k;
    logic [WORD_W-1:0] r_prev, n_prev;
    logic              r_out_valid;
    t_result           r_out;

    t_result                          res;
    logic                             emit;
    logic                             out_free;
    logic [BAD_W-1:0]                 bad_inc;
    logic [BAD_W-1:0]                 bad_end;
    t_kind                            end_kind;
    logic [LABEL_CHARS-1:0][CHAR_W-1:0] lbl_ch;
    logic                             trimming;
    logic [LEN_W-1:0]                 len_next;
    logic                             fits_now;
    logic                             fits_next;

    assign out_free  = !r_out_valid || o_res.ready;
    assign bad_inc   = (r_bad == BAD_MAX) ? r_bad : r_bad + BAD_W'(1);
    assign len_next  = len_step(r_len);
    assign fits_now  = write_fits(r_len, i_cfg.frame_bytes);
    assign fits_next = write_fits(len_next, i_cfg.frame_bytes);

    // Label characters, first in the top byte; trailing spaces and nulls cleared.
    always_comb begin
        trimming = 1'b1;
        lbl_ch   = i_cmd.label_raw;
        for (int i = 0; i < LABEL_CHARS; i++) begin
            if (trimming && ((lbl_ch[i] == CHAR_NUL) || (lbl_ch[i] == CHAR_SPACE))) begin
                lbl_ch[i] = CHAR_NUL;
            end else begin
                trimming = 1'b0;
            end
        end
    end

    // Outcome of a frame end that passed the minimum length.
    always_comb begin
        if (r_len == i_cfg.frame_bytes) begin
            bad_end  = '0;
            end_kind = KIND_COMPLETE;
        end else begin
            bad_end  = bad_inc;
            end_kind = KIND_WRONG;
        end
        if (bad_end >= i_cfg.bad_frame_limit) begin
            bad_end  = '0;
            end_kind = KIND_ABORT;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_open    = r_open;
        n_len     = r_len;
        n_bad     = r_bad;
        n_bank    = r_bank;
        n_k       = r_k;
        n_prev    = r_prev;
        o_cmd_pop = 1'b0;
        o_rd      = '0;
        o_rel     = '0;
        emit      = 1'b0;
        res       = '0;
        res.last_result = 1'b1;

        unique case (r_state)
            BK_IDLE: begin
                if (!i_cmd_empty) begin
                    unique case (i_cmd.ptype)
                        PKT_SYNC: begin
                            if (out_free) begin
                                o_cmd_pop = 1'b1;
                                n_len     = '0;
                                if (!r_open) begin
                                    n_open = 1'b1;
                                end else if (r_len < i_cfg.min_frame_bytes) begin
                                    n_bad    = bad_inc;
                                    emit     = 1'b1;
                                    res.kind = KIND_SHORT;
                                end else begin
                                    n_open   = 1'b0;
                                    n_bad    = bad_end;
                                    emit     = 1'b1;
                                    res.kind = end_kind;
                                end
                            end
                        end
                        PKT_LABEL: begin
                            if (!r_open) begin
                                o_cmd_pop = 1'b1;
                            end else if (out_free) begin
                                o_cmd_pop       = 1'b1;
                                emit            = 1'b1;
                                res.kind        = KIND_LABEL;
                                res.label_bytes = lbl_ch;
                                res.confidence  = i_cmd.conf;
                            end
                        end
                        PKT_IMAGE: begin
                            o_cmd_pop = 1'b1;
                            if (r_open) begin
                                o_rd.en   = 1'b1;
                                o_rd.addr = {i_cmd.bank, POS_W'(0)};
                                n_bank    = i_cmd.bank;
                                n_state   = BK_LOAD;
                            end else begin
                                o_rel.valid = 1'b1;
                                o_rel.bank  = i_cmd.bank;
                            end
                        end
                        default: begin
                            o_cmd_pop = 1'b1;
                        end
                    endcase
                end
            end
            BK_LOAD: begin
                n_prev    = i_rd_data;
                o_rd.en   = 1'b1;
                o_rd.addr = {r_bank, POS_W'(1)};
                n_k       = POS_W'(1);
                n_state   = BK_RUN;
            end
            BK_RUN: begin
                // Word k is in the read register; pair it with word k-1.
                if (!fits_now || out_free) begin
                    n_len  = len_next;
                    n_prev = i_rd_data;
                    if (fits_now) begin
                        emit             = 1'b1;
                        res.kind         = KIND_PIXEL;
                        res.write_offset = OFFSET_BITS'(r_len);
                        res.write_data   = {r_prev[HALF_W-1:0], i_rd_data[WORD_W-1:HALF_W]};
                        // Offsets only grow, so a later word cannot fit once this one is last.
                        res.last_result  = (r_k == LAST_POS) || !fits_next;
                    end
                    if (r_k == LAST_POS) begin
                        o_rel.valid = 1'b1;
                        o_rel.bank  = r_bank;
                        n_state     = BK_IDLE;
                    end else begin
                        o_rd.en   = 1'b1;
                        o_rd.addr = {r_bank, r_k + POS_W'(1)};
                        n_k       = r_k + POS_W'(1);
                    end
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
        res.bad_count = n_bad;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_open      <= 1'b0;
            r_len       <= '0;
            r_bad       <= '0;
            r_bank      <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_open  <= n_open;
            r_len   <= n_len;
            r_bad   <= n_bad;
            r_bank  <= n_bank;
            r_k     <= n_k;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev <= n_prev;
        if (emit) begin
            r_out <= res;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.kind         = r_out.kind;
    assign o_res.write_offset = r_out.write_offset;
    assign o_res.write_data   = r_out.write_data;
    assign o_res.label_bytes  = r_out.label_bytes;
    assign o_res.confidence   = r_out.confidence;
    assign o_res.bad_count    = r_out.bad_count;
    assign o_res.last_result  = r_out.last_result;

    `CPFA_ASSERT_NOW(a_run_in_frame, i_clk, i_rst_n, r_state == BK_RUN, r_open, "image replay while no frame is open")

endmodule

[rtl/camera_packet_frame_assembler.sv]
// ----------------------------------------------------------------------------
// Camera packet frame assembler
// Collects camera link packets, tracks frames and emits pixel, label and
// frame status results.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Transfer carries
//   -------  ---------  ----------------------------------------------------
//   i_rx     in         rx_word, packet_begin (one link word)
//   o_res    out        kind, write_offset, write_data, label_bytes,
//                       confidence, bad_count, last_result
//   i_cfg    in         reg_index, wr_data (register write, always ready)
//
// Link words are taken one per cycle while the packet bank being filled is
// free and the command queue has room. An image packet holds the back end
// while it is read out of the packet memory, one read per cycle unless the
// result output stalls it; sync and label packets are handled in the idle
// state alone. Reset is synchronous and active low; there is no clearing
// pass. A stalled result output holds the back end, which fills the queue
// and the second bank before the input side stalls.
//
// The design splits into a front end that writes words into a two-bank
// packet memory and classifies each finished packet, a two-entry command
// queue, and a back end that owns all frame state. Because the back end
// handles packets strictly in order, the frame state it sees is exactly the
// state each packet would meet when it completed on the link.
module camera_packet_frame_assembler (
    input  logic       i_clk,
    input  logic       i_rst_n,
    cpfa_rx_if.sink    i_rx,
    cpfa_res_if.source o_res,
    cpfa_cfg_if.sink   i_cfg
);
    import cpfa_pkg::*;

    t_cfg      r_cfg, n_cfg;
    t_cmd      push_cmd;
    t_cmd      head_cmd;
    logic      cmd_push;
    logic      cmd_pop;
    logic      cmd_empty;
    logic      cmd_full;
    t_rd_req   rd_req;
    logic [WORD_W-1:0] rd_data;
    t_bank_rel bank_rel;

    // Register writes land straight in the configuration register, so the write channel never stalls.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.reg_index)
                REG_FRAME_BYTES:     n_cfg.frame_bytes     = i_cfg.wr_data;
                REG_MIN_FRAME_BYTES: n_cfg.min_frame_bytes = i_cfg.wr_data;
                REG_BAD_LIMIT:       n_cfg.bad_frame_limit = i_cfg.wr_data[BAD_W-1:0];
                default:             n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.frame_bytes     <= RESET_FRAME_BYTES;
            r_cfg.min_frame_bytes <= RESET_MIN_BYTES;
            r_cfg.bad_frame_limit <= RESET_BAD_LIMIT;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // Front end: packet collection and classification.
    cpfa_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rx       (i_rx),
        .o_cmd      (push_cmd),
        .o_cmd_push (cmd_push),
        .i_cmd_full (cmd_full),
        .i_rd       (rd_req),
        .o_rd_data  (rd_data),
        .i_rel      (bank_rel)
    );

    // Queue that lets the two halves stall independently.
    cpfa_cmd_fifo u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_cmd   (push_cmd),
        .i_pop   (cmd_pop),
        .o_head  (head_cmd),
        .o_empty (cmd_empty),
        .o_full  (cmd_full)
    );

    // Back end: frame tracking, image replay and the result register.
    cpfa_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (head_cmd),
        .i_cmd_empty (cmd_empty),
        .o_cmd_pop   (cmd_pop),
        .o_rd        (rd_req),
        .i_rd_data   (rd_data),
        .o_rel       (bank_rel),
        .o_res       (o_res)
    );

endmodule

[dv/camera_packet_frame_assembler_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Camera packet frame assembler testbench
// Sends camera link packets (sync, image, label, noise and broken ones) under
// several register settings. A cycle-level mirror of the frame state predicts
// each pixel write, label and frame report, and every result transfer is
// compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module camera_packet_frame_assembler_tb;
    import cpfa_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int GAP_PCT       = 13;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 300000;

    // The register index that no register answers to.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;

    typedef logic [WORD_W-1:0] t_packet [PACKET_WORDS];

    logic i_clk;
    logic i_rst_n;

    cpfa_rx_if  rx_ch ();
    cpfa_res_if res_ch ();
    cpfa_cfg_if cfg_ch ();

    camera_packet_frame_assembler u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (rx_ch.sink),
        .o_res   (res_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    // Mirror of the block: collected packet, frame state and registers.
    logic [WORD_W-1:0] link_packet [PACKET_WORDS];
    logic [POS_W-1:0]  next_pos;
    logic              frame_active;
    logic [LEN_W-1:0]  frame_len;
    logic [BAD_W-1:0]  bad_frames;
    logic [LEN_W-1:0]  cfg_frame_bytes;
    logic [LEN_W-1:0]  cfg_min_bytes;
    logic [BAD_W-1:0]  cfg_bad_limit;

    // Results the block still owes us, oldest first.
    t_result expected_q[$];

    int  fail_count;
    int  words_sent;
    int  cycle_count;
    int  hold_left;
    bit  rx_gaps_on;
    bit  res_gaps_on;
    event hold_go;

    // ------------------------------------------------------------------------
    // Clock and run limit
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // A hung handshake or a missing result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------
    function automatic logic [BAD_W-1:0] bump_bad(input logic [BAD_W-1:0] b);
        return (b == BAD_MAX) ? BAD_MAX : b + 1'b1;
    endfunction

    // Every result carries the bad frame count as it stands after the event.
    function automatic void push_result(input t_kind k, input logic [OFFSET_BITS-1:0] off,
                                        input logic [WORD_W-1:0] data,
                                        input logic [LABEL_W-1:0] text,
                                        input logic [CONF_W-1:0] conf);
        t_result r;
        r.kind         = k;
        r.write_offset = off;
        r.write_data   = data;
        r.label_bytes  = text;
        r.confidence   = conf;
        r.bad_count    = bad_frames;
        r.last_result  = 1'b0;
        expected_q.push_back(r);
    endfunction

    // A sync packet opens a frame, restarts a short one, or closes it with a
    // report. The abort check is only made when a frame actually closes.
    function automatic void frame_sync_event();
        t_kind k;
        if (!frame_active) begin
            frame_active = 1'b1;
            frame_len    = '0;
        end else if (frame_len < cfg_min_bytes) begin
            frame_len  = '0;
            bad_frames = bump_bad(bad_frames);
            push_result(KIND_SHORT, '0, '0, '0, '0);
        end else begin
            frame_active = 1'b0;
            if (frame_len == cfg_frame_bytes) begin
                bad_frames = '0;
                k = KIND_COMPLETE;
            end else begin
                bad_frames = bump_bad(bad_frames);
                k = KIND_WRONG;
            end
            frame_len = '0;
            if (bad_frames >= cfg_bad_limit) begin
                bad_frames = '0;
                k = KIND_ABORT;
            end
            push_result(k, '0, '0, '0, '0);
        end
    endfunction

    // Six characters from the low half of word 0 and all of word 1; trailing
    // spaces and nulls are cleared, everything before the last real one stays.
    function automatic void label_event();
        logic [CHAR_W-1:0]  ch [LABEL_CHARS];
        logic [LABEL_W-1:0] text;
        bit                 trimming;
        ch[0] = link_packet[0][15:8];
        ch[1] = link_packet[0][7:0];
        ch[2] = link_packet[1][31:24];
        ch[3] = link_packet[1][23:16];
        ch[4] = link_packet[1][15:8];
        ch[5] = link_packet[1][7:0];
        trimming = 1'b1;
        for (int i = LABEL_CHARS - 1; i >= 0; i--) begin
            if (trimming && (ch[i] == CHAR_NUL || ch[i] == CHAR_SPACE)) begin
                ch[i] = CHAR_NUL;
            end else begin
                trimming = 1'b0;
            end
        end
        text = '0;
        for (int i = 0; i < LABEL_CHARS; i++) begin
            text = {text[LABEL_W-CHAR_W-1:0], ch[i]};
        end
        push_result(KIND_LABEL, '0, '0, text, link_packet[2][31:24]);
    endfunction

    // Each payload word joins the low half of one word with the high half of
    // the next. The length always advances; the write only when it fits.
    function automatic void pixel_event();
        logic [WORD_W-1:0] data;
        logic [LEN_W+1:0]  end_pos;
        for (int i = 0; i < PACKET_WORDS - 1; i++) begin
            data    = {link_packet[i][HALF_W-1:0], link_packet[i+1][WORD_W-1:HALF_W]};
            end_pos = {2'b00, frame_len} + (LEN_W + 2)'(BYTES_PER_WORD);
            if (end_pos <= {2'b00, cfg_frame_bytes} &&
                end_pos <= ((LEN_W + 2)'(1) << OFFSET_BITS)) begin
                push_result(KIND_PIXEL, frame_len[OFFSET_BITS-1:0], data, '0, '0);
            end
            frame_len = (end_pos > {2'b00, LEN_MAX}) ? LEN_MAX : end_pos[LEN_W-1:0];
        end
    endfunction

    function automatic void absorb_link_word(input logic [WORD_W-1:0] w, input logic first);
        int               owed_before;
        logic [POS_W-1:0] pos;
        t_result          r;
        if (first) begin
            next_pos = '0;
        end
        pos = next_pos;
        link_packet[pos] = w;
        next_pos = pos + 1'b1;
        if (pos == LAST_POS) begin
            owed_before = expected_q.size();
            if (link_packet[0] == SYNC_WORD && link_packet[1] == SYNC_WORD) begin
                frame_sync_event();
            end else if (frame_active) begin
                if (link_packet[0][WORD_W-1:HALF_W] == TAG_LABEL &&
                    link_packet[LAST_POS][HALF_W-1:0] == TAG_LABEL) begin
                    label_event();
                end else if (link_packet[0][WORD_W-1:HALF_W] == TAG_IMAGE &&
                             link_packet[LAST_POS][HALF_W-1:0] == TAG_IMAGE) begin
                    pixel_event();
                end
            end
            if (expected_q.size() > owed_before) begin
                r = expected_q[expected_q.size() - 1];
                r.last_result = 1'b1;
                expected_q[expected_q.size() - 1] = r;
            end
        end
    endfunction

    // Every accepted link word goes through the mirror at the edge of its
    // transfer, so the predictions are in place before any result can show.
    always @(posedge i_clk) begin
        if (i_rst_n && rx_ch.valid && rx_ch.ready) begin
            absorb_link_word(rx_ch.rx_word, rx_ch.packet_begin);
        end
    end

    // Register writes land in the mirror at the edge of their transfer.
    always @(posedge i_clk) begin
        if (i_rst_n && cfg_ch.valid && cfg_ch.ready) begin
            case (cfg_ch.reg_index)
                REG_FRAME_BYTES:     cfg_frame_bytes = cfg_ch.wr_data;
                REG_MIN_FRAME_BYTES: cfg_min_bytes   = cfg_ch.wr_data;
                REG_BAD_LIMIT:       cfg_bad_limit   = cfg_ch.wr_data[BAD_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // Result side: ready pattern, long hold-off and checking
    // ------------------------------------------------------------------------
    // The hold-off runs on its own so the sender keeps offering words meanwhile.
    initial begin
        hold_left = 0;
        forever begin
            @(hold_go);
            hold_left <= HOLD_CYCLES;
            do begin
                @(posedge i_clk);
                hold_left <= hold_left - 1;
            end while (hold_left > 1);
        end
    end

    always @(posedge i_clk) begin
        res_ch.ready <= (hold_left == 0) && (!res_gaps_on || $urandom_range(99) >= GAP_PCT);
    end

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, got %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (expected_q.size() == 0) begin
                $error("result transfer with nothing expected: kind %0d", res_ch.kind);
                fail_count++;
            end else begin
                want = expected_q.pop_front();
                check_field("kind", want.kind, res_ch.kind);
                check_field("write_offset", want.write_offset, res_ch.write_offset);
                check_field("write_data", want.write_data, res_ch.write_data);
                check_field("label_bytes", want.label_bytes, res_ch.label_bytes);
                check_field("confidence", want.confidence, res_ch.confidence);
                check_field("bad_count", want.bad_count, res_ch.bad_count);
                check_field("last_result", want.last_result, res_ch.last_result);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Link side and register writes
    // ------------------------------------------------------------------------
    // One link word transfer, with an occasional gap in front of it. Valid
    // stays high after the transfer; whoever comes next decides to lower it.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic first);
        while (rx_gaps_on && $urandom_range(99) < GAP_PCT) begin
            rx_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        rx_ch.valid        <= 1'b1;
        rx_ch.rx_word      <= w;
        rx_ch.packet_begin <= first;
        do @(posedge i_clk); while (!rx_ch.ready);
        words_sent++;
    endtask

    task automatic send_packet(input t_packet p, input logic with_begin);
        for (int i = 0; i < PACKET_WORDS; i++) begin
            send_word(p[i], with_begin && (i == 0));
        end
    endtask

    // One register write transfer; valid stays up for a following write.
    task automatic cfg_xfer(input logic [CFG_IDX_W-1:0] idx, input logic [LEN_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.wr_data   <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
    endtask

    task automatic apply_config(input logic [LEN_W-1:0] fb, input logic [LEN_W-1:0] min_fb,
                                input logic [BAD_W-1:0] limit);
        cfg_xfer(REG_FRAME_BYTES, fb);
        cfg_xfer(REG_MIN_FRAME_BYTES, min_fb);
        cfg_xfer(REG_BAD_LIMIT, LEN_W'(limit));
        cfg_ch.valid <= 1'b0;
    endtask

    // Registers may only change with the block at rest. Packets that emit
    // nothing can still be in the back end when the last result has left,
    // so a fixed settling time follows the drained queue.
    task automatic wait_idle();
        rx_ch.valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Packet builders
    // ------------------------------------------------------------------------
    function automatic void random_packet(output t_packet p);
        for (int i = 0; i < PACKET_WORDS; i++) begin
            p[i] = $urandom;
        end
    endfunction

    function automatic void sync_packet(output t_packet p);
        random_packet(p);
        p[0] = SYNC_WORD;
        p[1] = SYNC_WORD;
    endfunction

    function automatic void image_packet(output t_packet p);
        random_packet(p);
        p[0][WORD_W-1:HALF_W]        = TAG_IMAGE;
        p[LAST_POS][HALF_W-1:0]      = TAG_IMAGE;
    endfunction

    function automatic void label_packet(output t_packet p, input logic [LABEL_W-1:0] text,
                                         input logic [CONF_W-1:0] conf);
        random_packet(p);
        p[0]                    = {TAG_LABEL, text[47:32]};
        p[1]                    = text[31:0];
        p[2][31:24]             = conf;
        p[LAST_POS][HALF_W-1:0] = TAG_LABEL;
    endfunction

    // Random characters with a random tail of spaces and nulls.
    function automatic logic [LABEL_W-1:0] random_label_text();
        logic [LABEL_W-1:0] text;
        int                 tail;
        text = LABEL_W'({$urandom, $urandom});
        tail = $urandom_range(LABEL_CHARS);
        for (int i = 0; i < tail; i++) begin
            text[i*CHAR_W +: CHAR_W] = $urandom_range(1) ? CHAR_SPACE : CHAR_NUL;
        end
        return text;
    endfunction

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Reset registers: a packet before any sync is ignored, then a frame
    // opens, carries pixels and a label, and its second sync comes far below
    // the reset minimum length, so it restarts as short.
    task automatic test_reset_registers();
        t_packet p;
        image_packet(p);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
        image_packet(p);
        p[1] = '0;
        p[2] = '1;
        send_packet(p, 1'b1);
        label_packet(p, {"CAM01", CHAR_SPACE}, 8'hFF);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
    endtask

    // One image packet fills a 60-byte frame exactly; the length equals the
    // minimum, so the closing sync reports a complete frame.
    task automatic test_complete_frame();
        t_packet p;
        wait_idle();
        apply_config(18'd60, 18'd60, 3'd7);
        image_packet(p);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
    endtask

    // Labels: nothing to trim, an inner space kept before a trailing mix of
    // nulls and spaces, all blanks, and all ones.
    task automatic test_label_trimming();
        t_packet p;
        sync_packet(p);
        send_packet(p, 1'b1);
        label_packet(p, "XYZ123", 8'h00);
        send_packet(p, 1'b1);
        label_packet(p, {"A B", CHAR_NUL, CHAR_SPACE, CHAR_NUL}, 8'h5A);
        send_packet(p, 1'b1);
        label_packet(p, {CHAR_SPACE, CHAR_NUL, CHAR_SPACE, CHAR_SPACE, CHAR_NUL, CHAR_SPACE},
                     8'hA5);
        send_packet(p, 1'b1);
        label_packet(p, '1, 8'hFF);
        send_packet(p, 1'b1);
    endtask

    // A 4-byte frame takes only the first pixel word; a second image packet
    // emits nothing at all. Two wrong lengths in a row reach a limit of two.
    task automatic test_wrong_length_and_abort();
        t_packet p;
        wait_idle();
        apply_config(18'd4, 18'd0, 3'd2);
        image_packet(p);
        send_packet(p, 1'b1);
        image_packet(p);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
    endtask

    // With a limit of zero even a frame of the right length aborts.
    task automatic test_zero_limit();
        t_packet p;
        wait_idle();
        apply_config(18'd60, 18'd0, 3'd0);
        sync_packet(p);
        send_packet(p, 1'b1);
        image_packet(p);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
    endtask

    // Packets the block must ignore: one cut short by a new packet start, a
    // half sync, a head tag without its tail, and an image with no frame.
    task automatic test_ignored_packets();
        t_packet p;
        sync_packet(p);
        for (int i = 0; i < 5; i++) begin
            send_word(p[i], i == 0);
        end
        sync_packet(p);
        p[1] = ~SYNC_WORD;
        send_packet(p, 1'b1);
        image_packet(p);
        send_packet(p, 1'b1);
        sync_packet(p);
        send_packet(p, 1'b1);
        image_packet(p);
        p[LAST_POS][HALF_W-1:0] = TAG_LABEL;
        send_packet(p, 1'b1);
        label_packet(p, "ABCDEF", 8'h11);
        p[0][WORD_W-1:HALF_W] = TAG_IMAGE;
        send_packet(p, 1'b1);
    endtask

    // Mostly well-formed frames with random content, plus lone syncs, noise
    // packets and broken ones (cut short, or sent without a start mark).
    task automatic run_random_traffic(input int budget, input int max_images);
        t_packet p;
        int      stop_at;
        int      pick;
        int      cut;
        stop_at = words_sent + budget;
        while (words_sent < stop_at) begin
            pick = $urandom_range(99);
            if (pick < 65) begin
                sync_packet(p);
                send_packet(p, 1'b1);
                repeat ($urandom_range(max_images)) begin
                    if ($urandom_range(4) == 0) begin
                        label_packet(p, random_label_text(), CONF_W'($urandom));
                    end else begin
                        image_packet(p);
                    end
                    send_packet(p, 1'b1);
                end
                sync_packet(p);
                send_packet(p, 1'b1);
            end else if (pick < 75) begin
                sync_packet(p);
                send_packet(p, 1'b1);
            end else if (pick < 85) begin
                random_packet(p);
                case ($urandom_range(2))
                    0:       p[0][WORD_W-1:HALF_W] = TAG_IMAGE;
                    1:       p[0][WORD_W-1:HALF_W] = TAG_LABEL;
                    default: ;
                endcase
                send_packet(p, 1'b1);
            end else begin
                image_packet(p);
                if ($urandom_range(1)) begin
                    cut = $urandom_range(1, PACKET_WORDS - 1);
                    for (int i = 0; i < cut; i++) begin
                        send_word(p[i], i == 0);
                    end
                end else begin
                    send_packet(p, 1'b0);
                end
            end
        end
    endtask

    task automatic test_random_frames();
        wait_idle();
        apply_config(LEN_W'(60 * $urandom_range(1, 3)), LEN_W'($urandom_range(0, 120)),
                     BAD_W'($urandom_range(1, 7)));
        run_random_traffic(140, 4);
    endtask

    // A long stretch with no gaps on either side, registers random over their
    // full widths.
    task automatic test_back_to_back();
        wait_idle();
        rx_gaps_on  = 1'b0;
        res_gaps_on = 1'b0;
        apply_config(LEN_W'($urandom), LEN_W'($urandom), BAD_W'($urandom));
        run_random_traffic(140, 3);
        rx_gaps_on  = 1'b1;
        res_gaps_on = 1'b1;
    endtask

    // The result side holds off for a long time while image-heavy frames
    // keep coming, so the block fills up and stalls the link.
    task automatic test_output_backpressure();
        wait_idle();
        apply_config(18'd131072, 18'd0, 3'd0);
        -> hold_go;
        run_random_traffic(130, 6);
    endtask

    // A minimum of 131072 bytes makes every sync in an open frame a short restart,
    // so the bad count climbs and must stick at its top value. A write to
    // the unused register index goes along and must change nothing.
    task automatic test_bad_count_saturation();
        t_packet p;
        wait_idle();
        cfg_xfer(REG_UNUSED_IDX, LEN_W'($urandom));
        apply_config(LEN_MAX, 18'd131072, 3'd7);
        repeat (12) begin
            if ($urandom_range(3) == 0) begin
                label_packet(p, random_label_text(), CONF_W'($urandom));
            end else begin
                sync_packet(p);
            end
            send_packet(p, 1'b1);
        end
        sync_packet(p);
        send_packet(p, 1'b1);
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n             = 1'b0;
        rx_ch.valid         = 1'b0;
        rx_ch.rx_word       = '0;
        rx_ch.packet_begin  = 1'b0;
        res_ch.ready        = 1'b0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.reg_index    = REG_FRAME_BYTES;
        cfg_ch.wr_data      = '0;
        fail_count          = 0;
        words_sent          = 0;
        cycle_count         = 0;
        rx_gaps_on          = 1'b1;
        res_gaps_on         = 1'b1;
        for (int i = 0; i < PACKET_WORDS; i++) begin
            link_packet[i] = '0;
        end
        next_pos        = '0;
        frame_active    = 1'b0;
        frame_len       = '0;
        bad_frames      = '0;
        cfg_frame_bytes = RESET_FRAME_BYTES;
        cfg_min_bytes   = RESET_MIN_BYTES;
        cfg_bad_limit   = RESET_BAD_LIMIT;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_registers();
        test_complete_frame();
        test_label_trimming();
        test_wrong_length_and_abort();
        test_zero_limit();
        test_ignored_packets();
        test_random_frames();
        test_back_to_back();
        test_output_backpressure();
        test_bad_count_saturation();

        // Drain what is still owed, then give trailing work time to surface.
        wait_idle();

        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
